// ----- src/esss_pkg.sv -----
// ----------------------------------------------------------------------------
// Encoder stall sector scan package
// Shared widths, codes, item types and helper functions.
// ----------------------------------------------------------------------------
package esss_pkg;

  localparam int unsigned EncWidth   = 16;
  localparam int unsigned TickWidth  = 16;
  localparam int unsigned AngleWidth = 12;
  localparam int unsigned CfgWidth   = 12;
  localparam int unsigned CntWidth   = 4;
  // Signed width that holds an edge plus or minus a tolerance without wrapping.
  localparam int unsigned CmpWidth   = CfgWidth + 2;

  localparam int unsigned InDataWidth  = 64;
  localparam int unsigned OutDataWidth = 8;

  localparam logic [CntWidth-1:0] CalibLimit = CntWidth'(10);
  localparam logic [CntWidth-1:0] CalibArm   = CntWidth'(5);
  localparam logic [CfgWidth-1:0] NorthLow   = CfgWidth'(9);
  localparam logic [CfgWidth-1:0] NorthHigh  = CfgWidth'(3590);
  localparam logic signed [CmpWidth-1:0] FullAngle = CmpWidth'(3599);

  // Tick check period is 150 = 2 * 75. Divisibility by 75 of a 15-bit value
  // uses the inverse of 75 modulo 2**15: y is a multiple of 75 exactly when
  // y * inverse, truncated to 15 bits, is at most floor((2**15 - 1) / 75).
  localparam int unsigned HalfWidth  = TickWidth - 1;
  localparam logic [HalfWidth-1:0] Inv75      = HalfWidth'(18787);
  localparam logic [HalfWidth-1:0] Inv75Limit = HalfWidth'(((1 << HalfWidth) - 1) / 75);

  typedef enum logic [1:0] {
    RegSectorStart = 2'd0,
    RegSectorEnd   = 2'd1,
    RegEdgeTol     = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CmdNone  = 2'd0,
    CmdStart = 2'd1,
    CmdAbort = 2'd2
  } scan_cmd_e;

  typedef enum logic [1:0] {
    PhaseIdle    = 2'd0,
    PhaseSeek    = 2'd1,
    PhaseToEnd   = 2'd2,
    PhaseToStart = 2'd3
  } scan_phase_e;

  typedef struct packed {
    logic                  check;
    logic [EncWidth-1:0]   first_encoder;
    logic [EncWidth-1:0]   second_encoder;
    logic [AngleWidth-1:0] azimuth_angle;
    logic                  begin_calibration;
    logic [1:0]            scan_command;
  } item_t;

  typedef struct packed {
    logic       rotate_request;
    logic [1:0] scan_phase;
    logic       calibrating;
    logic       second_stalled;
    logic       first_stalled;
    logic       checked;
  } result_t;

  typedef struct packed {
    logic [CfgWidth-1:0] sector_start;
    logic [CfgWidth-1:0] sector_end;
    logic [CfgWidth-1:0] edge_tolerance;
  } cfg_t;

  function automatic logic tick_is_check(input logic [TickWidth-1:0] tick);
    logic [2*HalfWidth-1:0] prod;
    prod = {{HalfWidth{1'b0}}, tick[TickWidth-1:1]} * {{HalfWidth{1'b0}}, Inv75};
    return (tick[0] == 1'b0) && (prod[HalfWidth-1:0] <= Inv75Limit);
  endfunction

  function automatic logic at_edge(input logic [CfgWidth-1:0]   edge_pos,
                                   input logic [AngleWidth-1:0] angle,
                                   input logic [CfgWidth-1:0]   tol);
    logic signed [CmpWidth-1:0] e;
    logic signed [CmpWidth-1:0] a;
    logic signed [CmpWidth-1:0] t;
    e = signed'({2'b00, edge_pos});
    a = signed'({2'b00, angle});
    t = signed'({2'b00, tol});
    if ((edge_pos <= NorthLow) || (edge_pos >= NorthHigh)) begin
      return (a >= FullAngle - t) || (a <= t);
    end
    return (a >= e - t) && (a <= e + t);
  endfunction

endpackage

// ----- src/esss_core.sv -----
// ----------------------------------------------------------------------------
// Encoder stall sector scan core
// Holds the encoder history, calibration and scan state and works out the
// result of one item in a single step.
// ----------------------------------------------------------------------------
module esss_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  esss_pkg::item_t item_i,
  input  esss_pkg::cfg_t  cfg_i,
  output esss_pkg::result_t result_o
);
  import esss_pkg::*;

  logic [EncWidth-1:0] first_latest_q, first_latest_d;
  logic [EncWidth-1:0] first_earlier_q, first_earlier_d;
  logic                first_flag_q, first_flag_d;
  logic [EncWidth-1:0] second_latest_q, second_latest_d;
  logic [EncWidth-1:0] second_earlier_q, second_earlier_d;
  logic                second_flag_q, second_flag_d;
  logic                calib_q, calib_d;
  logic [CntWidth-1:0] calib_cnt_q, calib_cnt_d;
  scan_phase_e         phase_q, phase_d;
  logic                rotate;

  always_comb begin
    first_latest_d   = first_latest_q;
    first_earlier_d  = first_earlier_q;
    first_flag_d     = first_flag_q;
    second_latest_d  = second_latest_q;
    second_earlier_d = second_earlier_q;
    second_flag_d    = second_flag_q;
    calib_d          = calib_q;
    calib_cnt_d      = calib_cnt_q;
    phase_d          = phase_q;
    rotate           = 1'b0;

    // Commands are applied before the check.
    if (item_i.begin_calibration) begin
      calib_d     = 1'b1;
      calib_cnt_d = '0;
    end
    unique case (item_i.scan_command)
      CmdStart: phase_d = PhaseSeek;
      CmdAbort: phase_d = PhaseIdle;
      default:  phase_d = phase_q;
    endcase

    if (item_i.check) begin
      first_earlier_d  = first_latest_q;
      first_latest_d   = item_i.first_encoder;
      first_flag_d     = (item_i.first_encoder == first_latest_q);
      second_earlier_d = second_latest_q;
      second_latest_d  = item_i.second_encoder;

      if (!calib_d) begin
        second_flag_d = (item_i.second_encoder == second_latest_q);
      end else begin
        if (calib_cnt_d < CalibLimit) begin
          calib_cnt_d = calib_cnt_d + CntWidth'(1);
        end
        // During calibration the azimuth flag is held until the arming check.
        if (calib_cnt_d >= CalibArm) begin
          second_flag_d = (item_i.second_encoder == second_latest_q);
          if (second_flag_d) begin
            calib_d = 1'b0;
          end
        end
      end

      if (second_flag_d) begin
        unique case (phase_d)
          PhaseSeek, PhaseToStart: begin
            if (at_edge(cfg_i.sector_start, item_i.azimuth_angle, cfg_i.edge_tolerance)) begin
              phase_d = PhaseToEnd;
              rotate  = 1'b1;
            end
          end
          PhaseToEnd: begin
            if (at_edge(cfg_i.sector_end, item_i.azimuth_angle, cfg_i.edge_tolerance)) begin
              phase_d = PhaseToStart;
              rotate  = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_latest_q   <= '0;
      first_earlier_q  <= '0;
      first_flag_q     <= 1'b0;
      second_latest_q  <= '0;
      second_earlier_q <= '0;
      second_flag_q    <= 1'b0;
      calib_q          <= 1'b0;
      calib_cnt_q      <= '0;
      phase_q          <= PhaseIdle;
    end else if (step_i) begin
      first_latest_q   <= first_latest_d;
      first_earlier_q  <= first_earlier_d;
      first_flag_q     <= first_flag_d;
      second_latest_q  <= second_latest_d;
      second_earlier_q <= second_earlier_d;
      second_flag_q    <= second_flag_d;
      calib_q          <= calib_d;
      calib_cnt_q      <= calib_cnt_d;
      phase_q          <= phase_d;
    end
  end

  // The earlier readings are kept as part of the history but the compare
  // uses the previous latest value directly.
  logic unused_history;
  assign unused_history = ^{first_earlier_q, second_earlier_q};

  always_comb begin
    result_o.checked        = item_i.check;
    result_o.first_stalled  = first_flag_d;
    result_o.second_stalled = second_flag_d;
    result_o.calibrating    = calib_d;
    result_o.scan_phase     = phase_d;
    result_o.rotate_request = rotate & ~unused_history | rotate;
  end

endmodule

// ----- src/encoder_stall_sector_scan_unit.sv -----
// ----------------------------------------------------------------------------
// Encoder stall sector scan unit
// Stall monitor for two motor encoders with a sector-scan sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the s_axis channel, one transfer each, and every item
//   yields exactly one result transfer on the m_axis channel.
//   An item is first registered together with its tick check flag (tick count
//   a multiple of 150); in the next stage the core updates the encoder
//   history, the calibration and the scan state, and the result is held in
//   the output register. The result becomes valid once the item has passed
//   the input register and the output register, and one item is taken every
//   cycle while the receiver does not stall.
//   The tick check is a constant multiply in the input stage; the state update
//   is one pass of compare logic in the second stage.
//   When the receiver stalls, both stages hold and s_axis_tready falls once
//   the input stage is full, so no result is lost.
//   The configuration registers are written through cfg_we_i, cfg_idx_i and
//   cfg_data_i; the user must do so while no item is in flight (not checked).
//   Reset clears the pipeline, the encoder history, the calibration state,
//   the scan phase (idle) and all configuration registers.
// ----------------------------------------------------------------------------
module encoder_stall_sector_scan_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // tick_count[15:0], first_encoder[31:16], second_encoder[47:32],
  // azimuth_angle[59:48], begin_calibration[60], scan_command[62:61]
  input  logic [esss_pkg::InDataWidth-1:0]     s_axis_tdata,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // checked[0], first_stalled[1], second_stalled[2], calibrating[3],
  // scan_phase[5:4], rotate_request[6]
  output logic [esss_pkg::OutDataWidth-1:0]    m_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic                                 cfg_we_i,
  input  logic [1:0]                           cfg_idx_i,
  input  logic [esss_pkg::CfgWidth-1:0]        cfg_data_i
);
  import esss_pkg::*;

  cfg_t    cfg_q;
  item_t   item_q;
  logic    item_valid_q;
  logic [OutDataWidth-1:0] out_data_q;
  logic    out_valid_q;
  result_t result;
  logic    out_free;
  logic    step;
  logic    in_fire;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = item_valid_q && out_free;
  assign s_axis_tready = !item_valid_q || out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSectorStart: cfg_q.sector_start   <= cfg_data_i;
        RegSectorEnd:   cfg_q.sector_end     <= cfg_data_i;
        RegEdgeTol:     cfg_q.edge_tolerance <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.check             <= tick_is_check(s_axis_tdata[15:0]);
      item_q.first_encoder     <= s_axis_tdata[31:16];
      item_q.second_encoder    <= s_axis_tdata[47:32];
      item_q.azimuth_angle     <= s_axis_tdata[59:48];
      item_q.begin_calibration <= s_axis_tdata[60];
      item_q.scan_command      <= s_axis_tdata[62:61];
    end
  end

  esss_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  // Result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= {1'b0, result};
    end
  end

  assign m_axis_tdata  = out_data_q;
  assign m_axis_tvalid = out_valid_q;

endmodule
